// File: rtl/huber_robust_weight_top_defines.svh
// Assertion macros shared by the Huber weight RTL.
`ifndef HUBER_ROBUST_WEIGHT_TOP_DEFINES_SVH
`define HUBER_ROBUST_WEIGHT_TOP_DEFINES_SVH

// Condition true in a cycle implies the consequence in the same cycle.
`define HRW_ASSERT_SAME(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("hrw assertion failed");

// Condition true in a cycle implies the consequence in the next cycle.
`define HRW_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("hrw assertion failed");

`endif

// File: rtl/hrw_pkg.sv
// Types and constants of the Huber robust weight block.
`default_nettype none
package hrw_pkg;

	localparam int IN_W   = 88;
	localparam int OUT_W  = 88;
	localparam int ADDR_W = 3;

	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_SCALE     = 1'b1;

	localparam logic [23:0] THRESHOLD_RESET = 24'd196608;
	localparam logic [31:0] SCALE_RESET     = 32'd65536;

	localparam logic [16:0] CNT_CAP   = 17'd65536;
	localparam logic [4:0]  SQRT_LAST = 5'd31;
	localparam logic [4:0]  DIV_LAST  = 5'd17;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SQRE = 11'b000_0000_0010,
		ST_SQIM = 11'b000_0000_0100,
		ST_ADD  = 11'b000_0000_1000,
		ST_SQRT = 11'b000_0001_0000,
		ST_CMP  = 11'b000_0010_0000,
		ST_PLO  = 11'b000_0100_0000,
		ST_PHI  = 11'b000_1000_0000,
		ST_NUM  = 11'b001_0000_0000,
		ST_DIV  = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic load;
		logic sq_re;
		logic sq_im;
		logic add;
		logic sqrt_step;
		logic cmp;
		logic p_lo;
		logic p_hi;
		logic num;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic inlier;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/hrw_ctrl.sv
// Sequencer for the Huber weight datapath.
`default_nettype none
module hrw_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire hrw_pkg::stat_t stat,
	output hrw_pkg::cmd_t      cmd
);

	hrw_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q;

	assign in_ready = (state_q == hrw_pkg::ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			hrw_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = hrw_pkg::ST_SQRE;
				end
			end
			hrw_pkg::ST_SQRE: begin
				cmd.sq_re = 1'b1;
				state_d = hrw_pkg::ST_SQIM;
			end
			hrw_pkg::ST_SQIM: begin
				cmd.sq_im = 1'b1;
				state_d = hrw_pkg::ST_ADD;
			end
			hrw_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				state_d = hrw_pkg::ST_SQRT;
			end
			hrw_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == hrw_pkg::SQRT_LAST) state_d = hrw_pkg::ST_CMP;
			end
			hrw_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = stat.inlier ? hrw_pkg::ST_DONE : hrw_pkg::ST_PLO;
			end
			hrw_pkg::ST_PLO: begin
				cmd.p_lo = 1'b1;
				state_d = hrw_pkg::ST_PHI;
			end
			hrw_pkg::ST_PHI: begin
				cmd.p_hi = 1'b1;
				state_d = hrw_pkg::ST_NUM;
			end
			hrw_pkg::ST_NUM: begin
				cmd.num = 1'b1;
				state_d = hrw_pkg::ST_DIV;
			end
			hrw_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == hrw_pkg::DIV_LAST) state_d = hrw_pkg::ST_DONE;
			end
			hrw_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = hrw_pkg::ST_IDLE;
				end
			end
			default: state_d = hrw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrw_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.add || cmd.num) cnt_q <= '0;
			else if (cmd.sqrt_step || cmd.div_step) cnt_q <= cnt_q + 5'd1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/hrw_dp.sv
// Datapath: squares, bitwise square root, weight division and running sums.
`default_nettype none
module hrw_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire hrw_pkg::cmd_t            cmd,
	output hrw_pkg::stat_t                stat,
	input  wire logic [hrw_pkg::IN_W-1:0] in_data,
	input  wire logic                     in_last,
	input  wire logic [23:0]              threshold,
	input  wire logic [31:0]              scale,
	input  wire logic                     out_ready,
	output logic                          out_valid,
	output logic [hrw_pkg::OUT_W-1:0]     out_data,
	output logic                          out_last
);

	logic [31:0] re_q, im_q;
	logic [17:0] prior_q;
	logic        last_q;
	logic [55:0] ts_q;
	logic [63:0] prod_q, rad_q;
	logic [45:0] lo_q;
	logic [31:0] root_q;
	logic [33:0] srem_q;
	logic [48:0] drem_q;
	logic [17:0] dnum_q, quot_q;
	logic        inl_q;
	logic [47:0] sum_q;
	logic [16:0] cnt_q;
	logic        ovalid_q;
	logic [17:0] w_out_q;
	logic        inl_out_q, last_out_q;
	logic [47:0] sum_out_q;
	logic [16:0] cnt_out_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [35:0] s_tmp, s_trial;
	logic [47:0] magx;
	logic        inl_now;
	logic [73:0] num;
	logic [48:0] d_tmp;
	logic [17:0] w;
	logic [48:0] sum_ext;
	logic [47:0] sum_new;
	logic [16:0] cnt_new;

	always_comb begin
		mul_a = re_q;
		mul_b = re_q;
		if (cmd.sq_im) begin
			mul_a = im_q;
			mul_b = im_q;
		end else if (cmd.p_lo) begin
			mul_a = {14'd0, prior_q};
			mul_b = {4'd0, ts_q[27:0]};
		end else if (cmd.p_hi) begin
			mul_a = {14'd0, prior_q};
			mul_b = {4'd0, ts_q[55:28]};
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// One result bit of the root per step, taking two radicand bits.
	assign s_tmp   = {srem_q, rad_q[63:62]};
	assign s_trial = {2'b00, root_q, 2'b01};

	assign magx    = {root_q, 16'd0};
	assign inl_now = ({8'd0, magx} <= ts_q);
	assign num     = {prod_q[45:0], 28'd0} + {28'd0, lo_q};
	assign d_tmp   = {drem_q[47:0], dnum_q[17]};

	assign w       = inl_q ? prior_q : quot_q;
	assign sum_ext = {1'b0, sum_q} + {31'd0, w};
	assign sum_new = sum_ext[48] ? {48{1'b1}} : sum_ext[47:0];
	assign cnt_new = (inl_q && (cnt_q < hrw_pkg::CNT_CAP)) ? cnt_q + 17'd1 : cnt_q;

	assign stat.inlier   = inl_now;
	assign stat.out_free = !ovalid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			re_q    <= in_data[31] ? 32'd0 - in_data[31:0] : in_data[31:0];
			im_q    <= in_data[63] ? 32'd0 - in_data[63:32] : in_data[63:32];
			prior_q <= in_data[81:64];
			last_q  <= in_last;
		end
		if (cmd.sq_re) ts_q <= 56'(threshold) * 56'(scale);
		if (cmd.sq_re || cmd.sq_im || cmd.p_lo || cmd.p_hi) prod_q <= mul_p;
		if (cmd.sq_im) rad_q <= prod_q;
		if (cmd.add) begin
			rad_q  <= rad_q + prod_q;
			root_q <= '0;
			srem_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (s_tmp >= s_trial) begin
				srem_q <= 34'(s_tmp - s_trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= s_tmp[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.cmp) inl_q <= inl_now;
		if (cmd.p_hi) lo_q <= prod_q[45:0];
		// The quotient stays below the prior weight, so the upper remainder starts below the divisor.
		if (cmd.num) begin
			drem_q <= {1'b0, num[65:18]};
			dnum_q <= num[17:0];
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			dnum_q <= {dnum_q[16:0], 1'b0};
			if (d_tmp >= {1'b0, magx}) begin
				drem_q <= d_tmp - {1'b0, magx};
				quot_q <= {quot_q[16:0], 1'b1};
			end else begin
				drem_q <= d_tmp;
				quot_q <= {quot_q[16:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			w_out_q    <= w;
			inl_out_q  <= inl_q;
			sum_out_q  <= sum_new;
			cnt_out_q  <= cnt_new;
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				sum_q    <= last_q ? 48'd0 : sum_new;
				cnt_q    <= last_q ? 17'd0 : cnt_new;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = {4'd0, cnt_out_q, sum_out_q, inl_out_q, w_out_q};
	assign out_last  = last_out_q;

endmodule
`default_nettype wire

// File: rtl/huber_robust_weight_top.sv
// Huber robust weight: residual magnitude, weight and running sums per segment.
//
// Input stream (s_axis): one segment per transaction, residual in Q15.16 and
// prior weight in Q2.16; tlast closes a set. Output stream (m_axis): one
// result per segment with the weight, the inlier flag and the running weight
// sum and inlier count including this segment; tlast repeats the input mark.
// Both sums restart at zero after a segment that carries tlast.
// One segment is in work at a time. The 32-step square root sets the core of
// the latency: an inlier passes the two squares, their sum, the root and the
// compare, an outlier adds a two-step product, one summing step and an 18-step
// division. The next segment is taken only after the result is registered, so
// a segment occupies the block until its result is written.
// A finished result waits in the output register; when m_axis_tready is low
// the block still takes and computes the next segment and only holds before
// writing its result. Reset clears the sums and the output valid flag, and
// restores threshold 3.0 and scale 1.0. APB: threshold at 0x0, scale at 0x4.
`default_nettype none
`include "huber_robust_weight_top_defines.svh"
module huber_robust_weight_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// res_re[31:0], res_im[63:32], prior_weight[81:64], zero fill
	input  wire logic [hrw_pkg::IN_W-1:0]    s_axis_tdata,
	input  wire logic                        s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// weight[17:0], inlier[18], weight_sum[66:19], inlier_count[83:67], zero fill
	output logic [hrw_pkg::OUT_W-1:0]        m_axis_tdata,
	output logic                             m_axis_tlast,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hrw_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [23:0] threshold_q;
	logic [31:0] scale_q;
	hrw_pkg::cmd_t  cmd;
	hrw_pkg::stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= hrw_pkg::THRESHOLD_RESET;
			scale_q     <= hrw_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				hrw_pkg::REG_THRESHOLD: threshold_q <= pwdata[23:0];
				hrw_pkg::REG_SCALE:     scale_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			hrw_pkg::REG_THRESHOLD: prdata = {8'd0, threshold_q};
			hrw_pkg::REG_SCALE:     prdata = scale_q;
			default:                prdata = '0;
		endcase
	end

	hrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hrw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.threshold (threshold_q),
		.scale     (scale_q),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	`HRW_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`HRW_ASSERT_SAME(a_count_capped, m_axis_tvalid,
		m_axis_tdata[83:67] <= hrw_pkg::CNT_CAP)
	`HRW_ASSERT_NEXT(a_finish_sets_valid, cmd.finish, m_axis_tvalid)

endmodule
`default_nettype wire
